// ===== rtl/core/fraction_reducer_assert.svh =====
// Assertion macros for the fraction reducer RTL.
// Needs clk and rst_n in the scope of each use; define NO_ASSERTIONS to drop them.
`ifndef FRACTION_REDUCER_ASSERT_SVH
`define FRACTION_REDUCER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define FRR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fraction_reducer: same-cycle check failed");
// next-cycle implication
`define FRR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fraction_reducer: next-cycle check failed");
`else
`define FRR_ASSERT_NOW(lbl, ante, cons)
`define FRR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/frr_pkg.sv =====
// Package for the fraction reducer: widths, microcode encoding and program ROM.
// No dependencies.
`default_nettype none

package frr_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int MAG_W      = DATA_WIDTH - 1;        // magnitude of a legal operand
  localparam int CNT_W      = $clog2(MAG_W);
  localparam int DIV_LAST   = MAG_W - 1;             // last restoring-division step
  localparam int UPC_W      = 4;

  // microprogram addresses
  typedef enum logic [UPC_W-1:0] {
    PC_WAIT  = 4'd0,
    PC_CHECK = 4'd1,
    PC_GCD   = 4'd2,
    PC_GFORM = 4'd3,
    PC_DIVN  = 4'd4,
    PC_SAVE  = 4'd5,
    PC_DIVD  = 4'd6,
    PC_EMIT  = 4'd7,
    PC_BACK  = 4'd8
  } upc_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_GCD,
    OP_GFORM,
    OP_DIV,
    OP_SAVE,
    OP_EMIT
  } uop_t;

  // jump taken when the condition holds, else fall through
  typedef enum logic [2:0] {
    CD_NEVER,
    CD_ALWAYS,
    CD_NO_IN,
    CD_SPECIAL,
    CD_GCD_BUSY,
    CD_DIV_MORE,
    CD_OUT_FULL
  } cond_t;

  typedef struct packed {
    uop_t  op;
    cond_t cond;
    upc_t  tgt;
    logic  take_in;
  } ucw_t;

  function automatic ucw_t ucode(upc_t pc);
    ucw_t w;
    case (pc)
      PC_WAIT:  w = '{op: OP_LOAD,  cond: CD_NO_IN,    tgt: PC_WAIT, take_in: 1'b1};
      PC_CHECK: w = '{op: OP_NOP,   cond: CD_SPECIAL,  tgt: PC_EMIT, take_in: 1'b0};
      PC_GCD:   w = '{op: OP_GCD,   cond: CD_GCD_BUSY, tgt: PC_GCD,  take_in: 1'b0};
      PC_GFORM: w = '{op: OP_GFORM, cond: CD_NEVER,    tgt: PC_WAIT, take_in: 1'b0};
      PC_DIVN:  w = '{op: OP_DIV,   cond: CD_DIV_MORE, tgt: PC_DIVN, take_in: 1'b0};
      PC_SAVE:  w = '{op: OP_SAVE,  cond: CD_NEVER,    tgt: PC_WAIT, take_in: 1'b0};
      PC_DIVD:  w = '{op: OP_DIV,   cond: CD_DIV_MORE, tgt: PC_DIVD, take_in: 1'b0};
      PC_EMIT:  w = '{op: OP_EMIT,  cond: CD_OUT_FULL, tgt: PC_EMIT, take_in: 1'b0};
      PC_BACK:  w = '{op: OP_NOP,   cond: CD_ALWAYS,   tgt: PC_WAIT, take_in: 1'b0};
      default:  w = '{op: OP_NOP,   cond: CD_ALWAYS,   tgt: PC_WAIT, take_in: 1'b0};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/frr_if.sv =====
// Valid/ready channel interfaces for the fraction reducer.
// Depends on frr_pkg for the data width.
`default_nettype none

interface frr_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [frr_pkg::DATA_WIDTH-1:0]   numer_in;
  logic signed [frr_pkg::DATA_WIDTH-1:0]   denom_in;

  modport source (output valid, numer_in, denom_in, input ready);
  modport sink   (input valid, numer_in, denom_in, output ready);
endinterface

interface frr_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [frr_pkg::DATA_WIDTH-1:0]   numer_out;
  logic        [frr_pkg::MAG_W-1:0]        denom_out;
  logic                                    error;

  modport source (output valid, numer_out, denom_out, error, input ready);
  modport sink   (input valid, numer_out, denom_out, error, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/fraction_reducer.sv =====
// Fraction reducer top level: microcoded sequencer plus GCD/divide datapath.
// Depends on frr_pkg, frr_if.sv and fraction_reducer_assert.svh.
//
//  channel | dir | payload                          | transfer when
//  in_ch   | in  | numer_in[31:0] s, denom_in[31:0] s | valid && ready
//  out_ch  | out | numer_out[31:0] s, denom_out[30:0], error | valid && ready
//
// An error or a zero numerator skips straight to the emit step. Otherwise the
// binary-GCD loop (one shift or compare-subtract per cycle) runs until an
// operand is zero; the two 31-step restoring divisions then share one
// subtractor.
// One item at a time: in_ch.ready is high only while the sequencer waits.
// Reset clears the microprogram counter and the output valid; nothing else.
// A held result stalls the sequencer at the emit step until it is taken.
`default_nettype none
`include "fraction_reducer_assert.svh"

module fraction_reducer (
  input  wire         clk,
  input  wire         rst_n,
  frr_in_if.sink      in_ch,
  frr_out_if.source   out_ch
);

  localparam int DW = frr_pkg::DATA_WIDTH;
  localparam int MW = frr_pkg::MAG_W;
  localparam int CW = frr_pkg::CNT_W;

  // ---------------- sequencer ----------------
  frr_pkg::upc_t pc_r, pc_nxt;
  frr_pkg::ucw_t cw;
  logic          cond_hit;

  // ---------------- datapath registers ----------------
  logic [MW-1:0] an_r, an_nxt;     // |numerator|
  logic [MW-1:0] ad_r, ad_nxt;     // |denominator|
  logic [MW-1:0] a_r, a_nxt;       // GCD operands
  logic [MW-1:0] b_r, b_nxt;
  logic [CW-1:0] k_r, k_nxt;       // shared power of two
  logic [MW-1:0] dvsr_r, dvsr_nxt; // gcd
  logic [MW-1:0] rem_r, rem_nxt;
  logic [MW-1:0] quo_r, quo_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [MW-1:0] qn_r, qn_nxt;     // reduced |numerator|
  logic          neg_r, neg_nxt;
  logic          err_r, err_nxt;
  logic          zero_r, zero_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [DW-1:0] out_numer_r, out_numer_nxt;
  logic [MW-1:0] out_denom_r, out_denom_nxt;
  logic          out_err_r, out_err_nxt;

  // ---------------- helpers ----------------
  logic          in_xfer;
  logic          out_full;
  logic          gcd_busy;
  logic [DW-1:0] n_in, d_in;
  logic [DW-1:0] min_neg;
  logic [MW:0]   rsh, diff;
  logic [DW-1:0] qn_ext;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_full = out_valid_r && !out_ch.ready;
  assign gcd_busy = (a_r != '0) && (b_r != '0);
  assign n_in     = in_ch.numer_in;
  assign d_in     = in_ch.denom_in;
  assign min_neg  = {1'b1, {(DW-1){1'b0}}};
  assign rsh      = {rem_r, quo_r[MW-1]};
  assign diff     = rsh - {1'b0, dvsr_r};
  assign qn_ext   = {1'b0, qn_r};

  // control word fetch and input ready
  always_comb begin
    cw          = frr_pkg::ucode(pc_r);
    in_ch.ready = cw.take_in;
  end

  // next step: jump on condition, else fall through
  always_comb begin
    case (cw.cond)
      frr_pkg::CD_NEVER:    cond_hit = 1'b0;
      frr_pkg::CD_ALWAYS:   cond_hit = 1'b1;
      frr_pkg::CD_NO_IN:    cond_hit = !in_ch.valid;
      frr_pkg::CD_SPECIAL:  cond_hit = err_r || zero_r;
      frr_pkg::CD_GCD_BUSY: cond_hit = gcd_busy;
      frr_pkg::CD_DIV_MORE: cond_hit = cnt_r != CW'(frr_pkg::DIV_LAST);
      frr_pkg::CD_OUT_FULL: cond_hit = out_full;
      default:              cond_hit = 1'b0;
    endcase
    if (cond_hit) begin
      pc_nxt = cw.tgt;
    end else begin
      pc_nxt = frr_pkg::upc_t'(frr_pkg::UPC_W'(pc_r) + frr_pkg::UPC_W'(1));
    end
  end

  // datapath
  always_comb begin
    an_nxt        = an_r;
    ad_nxt        = ad_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    k_nxt         = k_r;
    dvsr_nxt      = dvsr_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    qn_nxt        = qn_r;
    neg_nxt       = neg_r;
    err_nxt       = err_r;
    zero_nxt      = zero_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_numer_nxt = out_numer_r;
    out_denom_nxt = out_denom_r;
    out_err_nxt   = out_err_r;

    case (cw.op)
      frr_pkg::OP_LOAD: begin
        if (in_xfer) begin
          an_nxt   = n_in[DW-1] ? MW'(~n_in + DW'(1)) : n_in[MW-1:0];
          ad_nxt   = d_in[DW-1] ? MW'(~d_in + DW'(1)) : d_in[MW-1:0];
          a_nxt    = an_nxt;
          b_nxt    = ad_nxt;
          k_nxt    = '0;
          neg_nxt  = n_in[DW-1] ^ d_in[DW-1];
          err_nxt  = (n_in == min_neg) || (d_in == min_neg) || (d_in == '0);
          zero_nxt = (n_in == '0);
        end
      end
      frr_pkg::OP_GCD: begin
        // Stein step: gcd(orig) = 2^k * gcd(a, b) throughout
        if (gcd_busy) begin
          if (!a_r[0] && !b_r[0]) begin
            a_nxt = a_r >> 1;
            b_nxt = b_r >> 1;
            k_nxt = k_r + CW'(1);
          end else if (!a_r[0]) begin
            a_nxt = a_r >> 1;
          end else if (!b_r[0]) begin
            b_nxt = b_r >> 1;
          end else if (a_r >= b_r) begin
            a_nxt = a_r - b_r;
          end else begin
            b_nxt = b_r - a_r;
          end
        end
      end
      frr_pkg::OP_GFORM: begin
        dvsr_nxt = MW'((a_r | b_r) << k_r);
        quo_nxt  = an_r;
        rem_nxt  = '0;
        cnt_nxt  = '0;
      end
      frr_pkg::OP_DIV: begin
        // restoring division, one quotient bit per cycle
        if (!diff[MW]) begin
          rem_nxt = diff[MW-1:0];
          quo_nxt = {quo_r[MW-2:0], 1'b1};
        end else begin
          rem_nxt = rsh[MW-1:0];
          quo_nxt = {quo_r[MW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + CW'(1);
      end
      frr_pkg::OP_SAVE: begin
        qn_nxt  = quo_r;
        quo_nxt = ad_r;
        rem_nxt = '0;
        cnt_nxt = '0;
      end
      frr_pkg::OP_EMIT: begin
        if (!out_full) begin
          out_valid_nxt = 1'b1;
          if (err_r) begin
            out_numer_nxt = '0;
            out_denom_nxt = '0;
            out_err_nxt   = 1'b1;
          end else if (zero_r) begin
            out_numer_nxt = '0;
            out_denom_nxt = MW'(1);
            out_err_nxt   = 1'b0;
          end else begin
            out_numer_nxt = neg_r ? (~qn_ext + DW'(1)) : qn_ext;
            out_denom_nxt = quo_r;
            out_err_nxt   = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= frr_pkg::PC_WAIT;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    an_r        <= an_nxt;
    ad_r        <= ad_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    k_r         <= k_nxt;
    dvsr_r      <= dvsr_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    cnt_r       <= cnt_nxt;
    qn_r        <= qn_nxt;
    neg_r       <= neg_nxt;
    err_r       <= err_nxt;
    zero_r      <= zero_nxt;
    out_numer_r <= out_numer_nxt;
    out_denom_r <= out_denom_nxt;
    out_err_r   <= out_err_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.numer_out = out_numer_r;
  assign out_ch.denom_out = out_denom_r;
  assign out_ch.error     = out_err_r;

  // ---------------- assertions ----------------
  `FRR_ASSERT_NOW(a_err_zero_payload, out_valid_r && out_err_r,
                  out_numer_r == '0 && out_denom_r == '0)
  `FRR_ASSERT_NOW(a_ok_denom_nonzero, out_valid_r && !out_err_r, out_denom_r != '0)
  `FRR_ASSERT_NOW(a_gcd_nonzero, pc_r == frr_pkg::PC_GFORM, (a_r | b_r) != '0)
  `FRR_ASSERT_NOW(a_div_by_nonzero,
                  pc_r == frr_pkg::PC_DIVN || pc_r == frr_pkg::PC_DIVD, dvsr_r != '0)
  `FRR_ASSERT_NEXT(a_div_leaves,
                   pc_r == frr_pkg::PC_DIVN && cnt_r == CW'(frr_pkg::DIV_LAST),
                   pc_r == frr_pkg::PC_SAVE)

endmodule

`default_nettype wire
